FILE: rtl/rpn_stack_calculator_defines.svh
// ----------------------------------------------------------------------------
// rpn stack calculator assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// same-cycle implication, reset disables
`define RPN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset disables
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rpn_pkg.sv
// ----------------------------------------------------------------------------
// rpn_pkg
// types and constants of the rpn stack calculator
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int DEPTH_W     = 7;

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_DIV0 = 2'd3;

    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [DATA_W-1:0] operand_value;
    } rpn_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } rpn_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/rpn_div.sv
// ----------------------------------------------------------------------------
// rpn_div
// radix-2 restoring signed divider, truncates toward zero, one bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_div
    import rpn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic [DATA_W-1:0] num,
    input  wire logic [DATA_W-1:0] den,
    output logic                   done,
    output logic [DATA_W-1:0]      quo
);

    localparam int STEP_W = $clog2(DATA_W);

    logic              run_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] den_reg;

    logic [DATA_W:0]   rem_sh;
    logic              fits;
    logic [DATA_W:0]   rem_sub;

    always_comb
    begin
        rem_sh  = {rem_reg, q_reg[DATA_W-1]};
        fits    = rem_sh >= {1'b0, den_reg};
        rem_sub = rem_sh - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // magnitude datapath
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            neg_reg <= num[DATA_W-1] ^ den[DATA_W-1];
            q_reg   <= num[DATA_W-1] ? (~num + 1'b1) : num;
            den_reg <= den[DATA_W-1] ? (~den + 1'b1) : den;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            q_reg   <= {q_reg[DATA_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? (~q_reg + 1'b1) : q_reg;

endmodule

`default_nettype wire

FILE: rtl/rpn_stack_calculator.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// push, error and no-op commands: result strobe registered from the read state
// add, subtract, multiply: result strobe registered from the write-back state after the read state
// divide: read state, divider run state, then write-back state, which registers the result strobe
// busy stays high until the result is issued; a new command is taken while done is high
// asynchronous reset empties the stack; stack memory contents are not cleared
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_calculator
    import rpn_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire rpn_req_t req,
    output logic          done,
    output rpn_rsp_t      rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_WB
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               done_reg, done_next;
    rpn_rsp_t           rsp_reg, rsp_next;
    logic [2:0]         cmd_reg;
    logic [DATA_W-1:0]  val_reg;
    logic [DATA_W-1:0]  res_reg, res_next;

    logic [DATA_W-1:0]  stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]  rd_a_reg;
    logic [DATA_W-1:0]  rd_b_reg;
    logic               rd_en;
    logic [STK_AW-1:0]  rd_a_addr;
    logic [STK_AW-1:0]  rd_b_addr;
    logic               wr_en;
    logic [STK_AW-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;

    logic               div_go;
    logic               div_done;
    logic [DATA_W-1:0]  div_quo;
    logic [DATA_W-1:0]  mul_lo;
    logic [DATA_W-1:0]  top_now;

    rpn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (rd_b_reg),
        .den   (rd_a_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign rd_en     = start && (state_reg == S_IDLE);
    assign rd_a_addr = STK_AW'(count_reg - CNT_W'(1));
    assign rd_b_addr = STK_AW'(count_reg - CNT_W'(2));

    // stack memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= stack_mem[rd_a_addr];
            rd_b_reg <= stack_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cmd_reg <= req.cmd;
            val_reg <= req.operand_value;
        end
        res_reg <= res_next;
    end

    assign mul_lo  = rd_b_reg * rd_a_reg;
    assign top_now = (count_reg != '0) ? rd_a_reg : '0;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = STK_AW'(count_reg - CNT_W'(2));
        wr_data    = res_reg;
        div_go     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rsp_next.status    = ST_OK;
                rsp_next.top_value = top_now;
                rsp_next.depth     = DEPTH_W'(count_reg);
                state_next         = S_IDLE;
                done_next          = 1'b1;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (count_reg == CNT_W'(STACK_DEPTH))
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            wr_en              = 1'b1;
                            wr_addr            = STK_AW'(count_reg);
                            wr_data            = val_reg;
                            count_next         = count_reg + CNT_W'(1);
                            rsp_next.top_value = val_reg;
                            rsp_next.depth     = DEPTH_W'(count_next);
                        end
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            rsp_next.status = ST_FEW;
                        end
                        else if (cmd_reg == CMD_DIV)
                        begin
                            if (rd_a_reg == '0)
                            begin
                                rsp_next.status = ST_DIV0;
                            end
                            else
                            begin
                                div_go     = 1'b1;
                                done_next  = 1'b0;
                                state_next = S_DIV;
                            end
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            state_next = S_WB;
                            if (cmd_reg == CMD_ADD)
                            begin
                                res_next = rd_b_reg + rd_a_reg;
                            end
                            else if (cmd_reg == CMD_SUB)
                            begin
                                res_next = rd_b_reg - rd_a_reg;
                            end
                            else
                            begin
                                res_next = mul_lo;
                            end
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_OK;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quo;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                wr_en              = 1'b1;
                count_next         = count_reg - CNT_W'(1);
                rsp_next.status    = ST_OK;
                rsp_next.top_value = res_reg;
                rsp_next.depth     = DEPTH_W'(count_next);
                done_next          = 1'b1;
                state_next         = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/rpn_checker.sv
// ----------------------------------------------------------------------------
// rpn_checker
// port-level checks of the rpn stack calculator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "rpn_stack_calculator_defines.svh"

module rpn_checker
    import rpn_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire logic     done,
    input wire rpn_rsp_t rsp
);

    `RPN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
    `RPN_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without transaction")
    `RPN_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `RPN_ASSERT_SAME(a_depth_range, done, rsp.depth <= DEPTH_W'(STACK_DEPTH),
                     "depth beyond stack size")
    `RPN_ASSERT_SAME(a_empty_top, done && (rsp.depth == '0), rsp.top_value == '0,
                     "empty stack with nonzero top")

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (.*);

`default_nettype wire
